// ----- hw/rtl/mfs_pkg.sv -----
`timescale 1ns / 1ps

package mfs_pkg;

  // Default sizes of the scheduler
  localparam int unsigned LEVELS_DEF = 5;
  localparam int unsigned PROCS_DEF  = 32;

  // Fixed field widths
  localparam int unsigned ID_W   = 5;
  localparam int unsigned LVL_W  = 3;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned QNT_W  = 4;
  localparam int unsigned IN_W   = 16;
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Event codes
  localparam logic [OP_W-1:0] OP_NEW     = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd1;
  localparam logic [OP_W-1:0] OP_IO_REQ  = 3'd2;
  localparam logic [OP_W-1:0] OP_IO_DONE = 3'd3;
  localparam logic [OP_W-1:0] OP_TERM    = 3'd4;

  // Register indexes
  localparam logic REG_QUANTUM_RELOAD = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDR,
    ST_EXEC,
    ST_SEL,
    ST_POP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_run;
    logic exec;
    logic sel;
    logic pop;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic dispatch;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/mfs_cfg.sv -----
`timescale 1ns / 1ps

module mfs_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mfs_pkg::APB_AW-1:0]   paddr,
  input  logic [mfs_pkg::APB_DW-1:0]   pwdata,
  output logic [mfs_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [mfs_pkg::QNT_W-1:0]    quantum_reload
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the reload register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_reload <= mfs_pkg::QNT_W'(1);
    end else if (wr_en && (paddr[2] == mfs_pkg::REG_QUANTUM_RELOAD)) begin
      quantum_reload <= pwdata[mfs_pkg::QNT_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == mfs_pkg::REG_QUANTUM_RELOAD) begin
      prdata = mfs_pkg::APB_DW'(quantum_reload);
    end
  end

endmodule

// ----- hw/rtl/mfs_ctrl.sv -----
`timescale 1ns / 1ps

module mfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  mfs_pkg::status_t  st,
  output mfs_pkg::cmd_t     cmd
);

  mfs_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      mfs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = mfs_pkg::ST_RDR;
        end
      end
      mfs_pkg::ST_RDR: begin
        cmd.rd_run = 1'b1;
        state_next = mfs_pkg::ST_EXEC;
      end
      mfs_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = st.dispatch ? mfs_pkg::ST_SEL : mfs_pkg::ST_DONE;
      end
      mfs_pkg::ST_SEL: begin
        cmd.sel    = 1'b1;
        state_next = mfs_pkg::ST_POP;
      end
      mfs_pkg::ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = mfs_pkg::ST_DONE;
      end
      mfs_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = mfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mfs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/mfs_dp.sv -----
`timescale 1ns / 1ps

module mfs_dp #(
  parameter int unsigned LEVELS = mfs_pkg::LEVELS_DEF,
  parameter int unsigned PROCS  = mfs_pkg::PROCS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mfs_pkg::cmd_t               cmd,
  output mfs_pkg::status_t            st,
  input  logic [mfs_pkg::IN_W-1:0]    s_tdata,
  input  logic [mfs_pkg::OP_W-1:0]    s_tuser,
  input  logic [mfs_pkg::QNT_W-1:0]   quantum_reload,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mfs_pkg::OUT_W-1:0]   m_tdata
);

  localparam int unsigned LW   = $clog2(LEVELS);
  localparam int unsigned PW   = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned CW   = $clog2(PROCS + 1);
  localparam int unsigned QAW  = $clog2(LEVELS * PROCS);
  localparam int unsigned NIDS = 2 ** mfs_pkg::ID_W;
  localparam logic [LW-1:0]  LV_LAST = LW'(LEVELS - 1);
  localparam logic [PW-1:0]  PTR_LAST = PW'(PROCS - 1);
  localparam logic [CW-1:0]  CNT_FULL = CW'(PROCS);
  localparam logic [QAW-1:0] PROCS_A = QAW'(PROCS);

  // Id to level-store index, reduced modulo the process count
  logic [PW-1:0] idx_tab [NIDS];
  for (genvar gi = 0; gi < NIDS; gi++) begin : g_idx
    localparam int unsigned RED = gi % PROCS;
    assign idx_tab[gi] = PW'(RED);
  end

  // Captured event
  logic [mfs_pkg::OP_W-1:0] op_r;
  logic [mfs_pkg::ID_W-1:0] pid_r, rid_r;
  logic [PW-1:0]            pidx_r, ridx_r;
  logic                     rvalid_r, tzero_r;
  logic [mfs_pkg::LVL_W-1:0] slevel_r;

  // Stores
  logic [LW-1:0]            lvl_mem [PROCS];
  logic [LW-1:0]            lvl_rd, plevel;
  logic [mfs_pkg::ID_W-1:0] q_mem [LEVELS * PROCS];
  logic [mfs_pkg::ID_W-1:0] q_rd;
  logic [PW-1:0]            head [LEVELS];
  logic [PW-1:0]            tail [LEVELS];
  logic [CW-1:0]            cnt  [LEVELS];
  logic [mfs_pkg::QNT_W-1:0] quantum;

  // Event decode
  logic                     push_en, lw_en, dispatch, q_dec, push_ok, full;
  logic [LW-1:0]            push_lv, lw_val, rep_level;
  logic [mfs_pkg::ID_W-1:0] push_id;
  logic [PW-1:0]            lw_addr;
  logic [QAW-1:0]           q_waddr, q_raddr;

  // Dispatch select
  logic [LEVELS-1:0]        nonempty;
  logic                     found, found_r;
  logic [LW-1:0]            sel_lv, sel_lv_r;

  // Result
  logic                     ovf_r, res_valid;
  logic [mfs_pkg::ID_W-1:0] res_id;
  logic [LW-1:0]            res_level;

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= s_tuser;
      pid_r    <= s_tdata[4:0];
      rvalid_r <= s_tdata[5];
      rid_r    <= s_tdata[10:6];
      slevel_r <= s_tdata[13:11];
      tzero_r  <= s_tdata[14];
      pidx_r   <= idx_tab[s_tdata[4:0]];
      ridx_r   <= idx_tab[s_tdata[10:6]];
    end
  end

  // Level store: read proc_id level, then running level; write in exec
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lvl_rd <= lvl_mem[idx_tab[s_tdata[4:0]]];
    end else if (cmd.rd_run) begin
      lvl_rd <= lvl_mem[ridx_r];
    end
    if (cmd.exec && lw_en) begin
      lvl_mem[lw_addr] <= lw_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_run) begin
      plevel <= lvl_rd;
    end
  end

  // Decode the event; lvl_rd holds the running process level here
  always_comb begin
    push_en  = 1'b0;
    lw_en    = 1'b0;
    dispatch = 1'b0;
    q_dec    = 1'b0;
    push_lv  = '0;
    push_id  = pid_r;
    lw_addr  = pidx_r;
    case (op_r)
      mfs_pkg::OP_NEW: begin
        push_lv  = (int'(slevel_r) > int'(LEVELS) - 1) ? LV_LAST : LW'(slevel_r);
        push_en  = 1'b1;
        lw_en    = 1'b1;
        dispatch = tzero_r;
      end
      mfs_pkg::OP_TICK: begin
        if (!rvalid_r) begin
          dispatch = 1'b1;
        end else if (quantum == '0) begin
          push_lv  = (int'(lvl_rd) >= int'(LEVELS) - 1) ? LV_LAST : lvl_rd + 1'b1;
          push_id  = rid_r;
          lw_addr  = ridx_r;
          push_en  = 1'b1;
          lw_en    = 1'b1;
          dispatch = 1'b1;
        end else begin
          q_dec = 1'b1;
        end
      end
      mfs_pkg::OP_IO_REQ: begin
        dispatch = 1'b1;
      end
      mfs_pkg::OP_IO_DONE: begin
        push_lv = (int'(plevel) > int'(LEVELS) - 1) ? LV_LAST : plevel;
        push_en = 1'b1;
        lw_en   = 1'b1;
      end
      default: begin
      end
    endcase
    lw_val    = push_lv;
    full      = (cnt[push_lv] == CNT_FULL);
    push_ok   = push_en && !full;
    rep_level = (lw_en && (lw_addr == ridx_r)) ? lw_val : lvl_rd;
  end

  assign q_waddr = QAW'(push_lv) * PROCS_A + QAW'(tail[push_lv]);

  // Pick the highest nonempty level
  always_comb begin
    sel_lv = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        sel_lv = LW'(i);
      end
    end
    found = |nonempty;
  end

  for (genvar gl = 0; gl < LEVELS; gl++) begin : g_ne
    assign nonempty[gl] = (cnt[gl] != '0);
  end

  assign q_raddr = QAW'(sel_lv) * PROCS_A + QAW'(head[sel_lv]);

  // Queue store: push in exec, pop read in select
  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      q_mem[q_waddr] <= push_id;
    end
    if (cmd.sel && found) begin
      q_rd <= q_mem[q_raddr];
    end
  end

  // Queue pointers, counts and quantum
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
      quantum <= '0;
    end else begin
      if (cmd.exec) begin
        if (push_ok) begin
          tail[push_lv] <= (tail[push_lv] == PTR_LAST) ? '0 : tail[push_lv] + 1'b1;
          cnt[push_lv]  <= cnt[push_lv] + 1'b1;
        end
        if (q_dec) begin
          quantum <= quantum - 1'b1;
        end
      end
      if (cmd.sel && found) begin
        head[sel_lv] <= (head[sel_lv] == PTR_LAST) ? '0 : head[sel_lv] + 1'b1;
        cnt[sel_lv]  <= cnt[sel_lv] - 1'b1;
        quantum      <= quantum_reload;
      end
    end
  end

  // Form the result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ovf_r     <= push_en && full;
      res_valid <= rvalid_r;
      res_id    <= rvalid_r ? rid_r : '0;
      res_level <= rvalid_r ? rep_level : '0;
    end
    if (cmd.sel) begin
      found_r  <= found;
      sel_lv_r <= sel_lv;
    end
    if (cmd.pop) begin
      res_valid <= found_r;
      res_id    <= found_r ? q_rd : '0;
      res_level <= found_r ? sel_lv_r : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {6'b0, ovf_r, mfs_pkg::LVL_W'(res_level), res_id, res_valid};
    end
  end

  assign st.dispatch = dispatch;
  assign st.out_free = !m_tvalid || m_tready;

  // A pop removes exactly one entry from the chosen level
  assert property (@(posedge clk) disable iff (rst)
    (cmd.sel && found) |=> (cnt[$past(sel_lv)] == $past(cnt[sel_lv]) - 1'b1))
    else $error("pop did not decrement the selected level count");

  // A dispatch that finds a process reloads the quantum
  assert property (@(posedge clk) disable iff (rst)
    (cmd.sel && found) |=> (quantum == $past(quantum_reload)))
    else $error("quantum not reloaded on dispatch");

  // No level ever holds more entries than processes
  for (genvar ga = 0; ga < LEVELS; ga++) begin : g_chk
    assert property (@(posedge clk) disable iff (rst) cnt[ga] <= CNT_FULL)
      else $error("level count above capacity");
  end

endmodule

// ----- hw/rtl/multilevel_feedback_scheduler_core.sv -----
`timescale 1ns / 1ps
// Multilevel feedback queue scheduler.
// Slave stream s_*: one scheduler event per item, the event code on s_tuser.
// Master stream m_*: exactly one result per event, the process that runs next.
// APB port: register 0 at address 0 holds the 4-bit quantum reload (reset 1);
// write it only while no event is in flight.
// Timing: an accepted event steps through ST_RDR and ST_EXEC, then ST_SEL and
// ST_POP when it dispatches, and ST_DONE, which loads the output register. The
// sequence is set by the level store, read once for the named process and once
// for the running one, and by the registered read of the queue store on a
// dispatch. A new event is accepted once the previous one has moved into the
// output register.
// Reset: all level queues are empty at once (counts and pointers clear), the
// quantum left is zero; no clearing pass over the stores is needed.
// Stall: a result waits in the output register while m_tready is low; the
// next event is processed up to its result and then held until the register
// frees.
module multilevel_feedback_scheduler_core #(
  parameter int unsigned LEVELS = mfs_pkg::LEVELS_DEF,
  parameter int unsigned PROCS  = mfs_pkg::PROCS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // proc_id[4:0], running_valid[5], running_id[10:6], start_level[13:11],
  // at_time_zero[14], zero[15]
  input  logic [mfs_pkg::IN_W-1:0]    s_tdata,
  // op[2:0]
  input  logic [mfs_pkg::OP_W-1:0]    s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // next_valid[0], next_id[5:1], next_level[8:6], queue_overflow[9], zero[15:10]
  output logic [mfs_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfs_pkg::APB_AW-1:0]  paddr,
  input  logic [mfs_pkg::APB_DW-1:0]  pwdata,
  output logic [mfs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  mfs_pkg::cmd_t              cmd;
  mfs_pkg::status_t           st;
  logic [mfs_pkg::QNT_W-1:0]  quantum_reload;

  mfs_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .quantum_reload (quantum_reload)
  );

  mfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mfs_dp #(
    .LEVELS (LEVELS),
    .PROCS  (PROCS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .quantum_reload (quantum_reload),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

endmodule

// ----- dv/mfs_sched_checker.sv -----
`timescale 1ns / 1ps

// Watches the event and result streams plus the APB port, keeps its own
// copy of the scheduler queues, and compares every result with the oldest
// prediction still pending.
module mfs_sched_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  // proc_id[4:0], running_valid[5], running_id[10:6], start_level[13:11],
  // at_time_zero[14], zero[15]
  input  logic [mfs_pkg::IN_W-1:0]    s_tdata,
  // op[2:0]
  input  logic [mfs_pkg::OP_W-1:0]    s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // next_valid[0], next_id[5:1], next_level[8:6], queue_overflow[9], zero[15:10]
  input  logic [mfs_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfs_pkg::APB_AW-1:0]  paddr,
  input  logic [mfs_pkg::APB_DW-1:0]  pwdata,
  input  logic [mfs_pkg::APB_DW-1:0]  prdata,
  input  logic                        pready,
  input  logic                        run_done,
  output int unsigned                 mismatch_count
);
  import mfs_pkg::*;

  localparam int unsigned NLVL = LEVELS_DEF;
  localparam int unsigned NPROC = PROCS_DEF;
  localparam logic [APB_AW-1:0] ADDR_RELOAD = APB_AW'(4 * REG_QUANTUM_RELOAD);

  typedef struct packed {
    logic             nvalid;
    logic [ID_W-1:0]  nid;
    logic [LVL_W-1:0] nlvl;
    logic             ovf;
  } sched_result_t;

  // Shadow scheduler state
  logic [LVL_W-1:0] proc_level [NPROC];
  logic [ID_W-1:0]  ready_mem [NLVL*NPROC];
  int unsigned      ready_head [NLVL];
  int unsigned      ready_tail [NLVL];
  int unsigned      ready_cnt [NLVL];
  logic [QNT_W-1:0] quantum_left;
  logic [QNT_W-1:0] quantum_reload;

  sched_result_t expected_next [$];
  sched_result_t want;
  int unsigned   result_idx;
  bit            tail_checked;

  task automatic log_mismatch(input string what);
    if (mismatch_count < 40) begin
      $display("[%0t] sched check: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  function automatic logic [LVL_W-1:0] clamp_level(input int unsigned lv);
    return (lv > NLVL - 1) ? LVL_W'(NLVL - 1) : LVL_W'(lv);
  endfunction

  // Append an id to a level FIFO; report false when the FIFO is full
  function automatic bit enqueue_ready(input int unsigned lv, input logic [ID_W-1:0] id);
    if (ready_cnt[lv] >= NPROC) return 1'b0;
    ready_mem[lv*NPROC + ready_tail[lv]] = id;
    ready_tail[lv] = (ready_tail[lv] + 1) % NPROC;
    ready_cnt[lv]++;
    return 1'b1;
  endfunction

  // Apply one event to the shadow state and work out the process that runs next
  function automatic sched_result_t predict_schedule(input logic [OP_W-1:0] op,
                                                     input logic [IN_W-1:0] ev);
    logic [ID_W-1:0]  pid;
    logic [ID_W-1:0]  rid;
    logic             rv;
    logic             tz;
    logic [LVL_W-1:0] slv;
    int unsigned      pidx;
    int unsigned      ridx;
    int unsigned      lv;
    bit               disp;
    bit               found;
    sched_result_t    res;
    pid = ev[4:0];
    rv = ev[5];
    rid = ev[10:6];
    slv = ev[13:11];
    tz = ev[14];
    pidx = pid % NPROC;
    ridx = rid % NPROC;
    disp = 1'b0;
    found = 1'b0;
    res = '0;
    case (op)
      OP_NEW: begin
        lv = clamp_level(slv);
        proc_level[pidx] = LVL_W'(lv);
        res.ovf = !enqueue_ready(lv, pid);
        disp = tz;
      end
      OP_TICK: begin
        if (!rv) begin
          disp = 1'b1;
        end else if (quantum_left == '0) begin
          // quantum used up: demote one level and requeue
          lv = clamp_level(proc_level[ridx] + 1);
          proc_level[ridx] = LVL_W'(lv);
          res.ovf = !enqueue_ready(lv, rid);
          disp = 1'b1;
        end else begin
          quantum_left = quantum_left - 1'b1;
        end
      end
      OP_IO_REQ: disp = 1'b1;
      OP_IO_DONE: begin
        lv = clamp_level(proc_level[pidx]);
        proc_level[pidx] = LVL_W'(lv);
        res.ovf = !enqueue_ready(lv, pid);
      end
      default: ;
    endcase
    if (disp) begin
      // pop the head of the highest nonempty level
      for (int l = 0; l < NLVL; l++) begin
        if (!found && ready_cnt[l] != 0) begin
          found = 1'b1;
          res.nvalid = 1'b1;
          res.nid = ready_mem[l*NPROC + ready_head[l]];
          res.nlvl = LVL_W'(l);
          ready_head[l] = (ready_head[l] + 1) % NPROC;
          ready_cnt[l]--;
          quantum_left = quantum_reload;
        end
      end
    end else if (rv) begin
      res.nvalid = 1'b1;
      res.nid = rid;
      res.nlvl = proc_level[ridx];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NPROC; p++) proc_level[p] = '0;
      for (int l = 0; l < NLVL; l++) begin
        ready_head[l] = 0;
        ready_tail[l] = 0;
        ready_cnt[l] = 0;
      end
      quantum_left = '0;
      quantum_reload = QNT_W'(1);
      expected_next.delete();
      result_idx = 0;
      tail_checked = 1'b0;
      mismatch_count = 0;
    end else begin
      // compare the result leaving the block with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_next.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with no event pending", result_idx));
        end else begin
          want = expected_next.pop_front();
          if (m_tdata[0] !== want.nvalid)
            log_mismatch($sformatf("result %0d next_valid got %b want %b",
                                   result_idx, m_tdata[0], want.nvalid));
          if (m_tdata[5:1] !== want.nid)
            log_mismatch($sformatf("result %0d next_id got %0d want %0d",
                                   result_idx, m_tdata[5:1], want.nid));
          if (m_tdata[8:6] !== want.nlvl)
            log_mismatch($sformatf("result %0d next_level got %0d want %0d",
                                   result_idx, m_tdata[8:6], want.nlvl));
          if (m_tdata[9] !== want.ovf)
            log_mismatch($sformatf("result %0d queue_overflow got %b want %b",
                                   result_idx, m_tdata[9], want.ovf));
          if (m_tdata[OUT_W-1:10] !== '0)
            log_mismatch($sformatf("result %0d padding bits not zero: %h",
                                   result_idx, m_tdata));
        end
        result_idx++;
      end

      // predict for each accepted event
      if (s_tvalid && s_tready) begin
        expected_next.push_back(predict_schedule(s_tuser, s_tdata));
      end

      // track register writes and check read-back
      if (psel && penable && pready && paddr == ADDR_RELOAD) begin
        if (pwrite) begin
          quantum_reload = pwdata[QNT_W-1:0];
        end else if (prdata !== APB_DW'(quantum_reload)) begin
          log_mismatch($sformatf("quantum_reload read %0d want %0d", prdata, quantum_reload));
        end
      end

      if (run_done && !tail_checked) begin
        tail_checked = 1'b1;
        if (expected_next.size() != 0)
          log_mismatch($sformatf("%0d events never produced a result", expected_next.size()));
      end
    end
  end

endmodule

// ----- dv/tb_multilevel_feedback_scheduler_core.sv -----
`timescale 1ns / 1ps

module tb_multilevel_feedback_scheduler_core;
  import mfs_pkg::*;

  localparam int unsigned NPROC = PROCS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 160;
  localparam int unsigned SETTLE = 10;
  localparam logic [APB_AW-1:0] ADDR_RELOAD = APB_AW'(4 * REG_QUANTUM_RELOAD);
  localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_TERM + 1'b1;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

  // stimulus flavors
  localparam int MODE_MIX = 0;
  localparam int MODE_FILL = 1;
  localparam int MODE_DRAIN = 2;

  // receiver stall patterns
  localparam int RX_STEADY = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_COMB = 2;

  localparam int OVF_BIT = 9;
  localparam int NVALID_BIT = 0;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic [OP_W-1:0]     s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                run_done = 1'b0;
  logic                hold_req = 1'b0;
  int unsigned         mismatch_count;

  int unsigned         sent_count = 0;
  int unsigned         recv_count = 0;
  int unsigned         ovf_seen = 0;
  int unsigned         idle_seen = 0;
  int unsigned         in_stall_cycles = 0;
  int unsigned         cycle_count = 0;
  int unsigned         op_hist [8];
  int unsigned         burst_left = 0;
  int unsigned         mid_reload = 0;
  logic [NPROC-1:0]    known_ids = '0;

  int unsigned         rx_hold = 0;
  int unsigned         rx_tick = 0;
  int                  rx_mode = RX_STEADY;
  bit                  hold_taken = 1'b0;

  multilevel_feedback_scheduler_core dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mfs_sched_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .run_done      (run_done),
    .mismatch_count(mismatch_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Count handshakes and stalls, and stop a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (!rst) begin
      if (s_tvalid && s_tready) sent_count <= sent_count + 1;
      if (s_tvalid && !s_tready) in_stall_cycles <= in_stall_cycles + 1;
      if (m_tvalid && m_tready) begin
        recv_count <= recv_count + 1;
        if (m_tdata[OVF_BIT]) ovf_seen <= ovf_seen + 1;
        if (!m_tdata[NVALID_BIT]) idle_seen <= idle_seen + 1;
      end
    end
  end

  // Receiver: one long hold-off on request, otherwise rotating stall patterns
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (hold_req && !hold_taken) begin
      m_tready <= 1'b0;
      rx_hold <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 48 == 0) rx_mode <= $urandom_range(RX_STEADY, RX_COMB);
      case (rx_mode)
        RX_STEADY: m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(0, 99) < 60);
        default:   m_tready <= (rx_tick % 4 != 0);
      endcase
    end
  end

  // Offer one event and hold it until accepted; gaps open between bursts
  task automatic send_event(input logic [OP_W-1:0] op, input logic [ID_W-1:0] pid,
                            input logic rv, input logic [ID_W-1:0] rid,
                            input logic [LVL_W-1:0] slv, input logic tz);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    if (op == OP_NEW) known_ids[ID_W'(pid % NPROC)] = 1'b1;
    op_hist[op]++;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {1'b0, tz, slv, rid, rv, pid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_known_id();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom_range(0, NPROC - 1)); while (!known_ids[id]);
    return id;
  endfunction

  // Draw one event, weighted by mode; level reads only hit ids already named
  task automatic send_random(input int mode);
    int unsigned     roll;
    int unsigned     w_new, w_tick, w_req, w_done, w_term, tz_pct;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] pid, rid;
    logic            rv, tz;
    logic [LVL_W-1:0] slv;
    case (mode)
      MODE_FILL: begin
        w_new = 50; w_tick = 10; w_req = 3; w_done = 32; w_term = 3; tz_pct = 5;
      end
      MODE_DRAIN: begin
        w_new = 10; w_tick = 40; w_req = 35; w_done = 5; w_term = 5; tz_pct = 50;
      end
      default: begin
        w_new = 25; w_tick = 30; w_req = 15; w_done = 15; w_term = 8; tz_pct = 20;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < w_new) op = OP_NEW;
    else if (roll < w_new + w_tick) op = OP_TICK;
    else if (roll < w_new + w_tick + w_req) op = OP_IO_REQ;
    else if (roll < w_new + w_tick + w_req + w_done) op = OP_IO_DONE;
    else if (roll < w_new + w_tick + w_req + w_done + w_term) op = OP_TERM;
    else op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

    pid = (op == OP_IO_DONE) ? pick_known_id() : ID_W'($urandom_range(0, NPROC - 1));
    if (mode == MODE_FILL && $urandom_range(0, 9) < 7) slv = LVL_W'($urandom_range(4, 7));
    else slv = LVL_W'($urandom_range(0, 7));
    tz = (op == OP_NEW) ? ($urandom_range(0, 99) < tz_pct) : 1'($urandom_range(0, 1));
    rv = ($urandom_range(0, 3) != 0);
    // a running id whose level gets read must be one already given a level
    if (rv && !(op == OP_IO_REQ || (op == OP_NEW && tz))) rid = pick_known_id();
    else rid = ID_W'($urandom_range(0, NPROC - 1));
    send_event(op, pid, rv, rid, slv, tz);
  endtask

  // Stop offering and wait until every pending result has left the block
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (recv_count != sent_count) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Change the quantum reload while idle and read it back
  task automatic set_reload(input logic [QNT_W-1:0] value);
    wait_idle();
    apb_access(1'b1, ADDR_RELOAD, APB_DW'(value));
    @(posedge clk);
    apb_access(1'b0, ADDR_RELOAD, '0);
  endtask

  initial begin
    foreach (op_hist[k]) op_hist[k] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queues: dispatch finds nothing
    send_event(OP_TICK, 5'd0, 1'b0, 5'd0, 3'd0, 1'b0);
    send_event(OP_IO_REQ, 5'd31, 1'b1, 5'd31, 3'd7, 1'b1);
    // new processes at the top level and past the bottom level
    send_event(OP_NEW, 5'd0, 1'b0, 5'd0, 3'd0, 1'b0);
    send_event(OP_NEW, 5'd31, 1'b1, 5'd0, 3'd7, 1'b0);
    // new process at time zero dispatches
    send_event(OP_NEW, 5'd5, 1'b0, 5'd0, 3'd4, 1'b1);
    // quantum runs down, then demotion with requeue and dispatch
    send_event(OP_TICK, 5'd0, 1'b1, 5'd0, 3'd0, 1'b0);
    send_event(OP_TICK, 5'd0, 1'b1, 5'd0, 3'd0, 1'b0);
    send_event(OP_IO_DONE, 5'd31, 1'b1, 5'd0, 3'd0, 1'b0);
    send_event(OP_IO_REQ, 5'd0, 1'b1, 5'd0, 3'd0, 1'b0);
    // demotion at the lowest level saturates
    send_event(OP_TICK, 5'd0, 1'b1, 5'd31, 3'd0, 1'b0);
    send_event(OP_TICK, 5'd0, 1'b1, 5'd31, 3'd0, 1'b0);
    // terminate and unused codes leave state alone
    send_event(OP_TERM, 5'd31, 1'b1, 5'd31, 3'd7, 1'b1);
    send_event(OP_TERM, 5'd0, 1'b0, 5'd17, 3'd0, 1'b0);
    send_event(OP_UNUSED_LO, 5'd12, 1'b1, 5'd5, 3'd2, 1'b1);
    send_event(OP_UNUSED_HI, 5'd31, 1'b1, 5'd0, 3'd7, 1'b0);
    // I/O done with the time-zero flag set does not dispatch
    send_event(OP_IO_DONE, 5'd0, 1'b0, 5'd31, 3'd7, 1'b1);
    // level rewritten by a second new event, then reported while running
    send_event(OP_NEW, 5'd31, 1'b1, 5'd31, 3'd0, 1'b0);
    send_event(OP_TICK, 5'd0, 1'b1, 5'd31, 3'd0, 1'b0);
    // drain down to an empty dispatch
    repeat (6) send_event(OP_IO_REQ, 5'd0, 1'b1, 5'd31, 3'd0, 1'b0);

    set_reload(QNT_W'(0));
    repeat (110) send_random(MODE_MIX);

    // fill the levels; the receiver goes quiet for a while in the middle
    set_reload('1);
    for (int i = 0; i < 100; i++) begin
      if (i == 12) hold_req <= 1'b1;
      send_random(MODE_FILL);
    end

    mid_reload = $urandom_range(2, 14);
    set_reload(QNT_W'(mid_reload));
    repeat (90) send_random(MODE_DRAIN);

    set_reload(QNT_W'(1));
    repeat (100) send_random(MODE_MIX);

    wait_idle();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d events: new %0d, tick %0d, req %0d, done %0d, term %0d, unused %0d",
             sent_count, op_hist[OP_NEW], op_hist[OP_TICK], op_hist[OP_IO_REQ],
             op_hist[OP_IO_DONE], op_hist[OP_TERM],
             op_hist[5] + op_hist[6] + op_hist[7]);
    $display("Reload 1, 0, 15, %0d, 1; %0d overflows, %0d idle picks, %0d input stall cycles",
             mid_reload, ovf_seen, idle_seen, in_stall_cycles);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- multilevel_feedback_scheduler_core.f -----
hw/rtl/mfs_pkg.sv
hw/rtl/mfs_cfg.sv
hw/rtl/mfs_ctrl.sv
hw/rtl/mfs_dp.sv
hw/rtl/multilevel_feedback_scheduler_core.sv
dv/mfs_sched_checker.sv
dv/tb_multilevel_feedback_scheduler_core.sv
